[design/mwr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mwr_pkg;

    localparam int WORD_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int BLEND_W = 17;
    localparam int VAL_W   = 40;
    localparam int OUT_W   = 18;
    localparam int MIPO_W  = 4;
    localparam int SLOT_N  = 8;

    localparam logic [1:0] QUAL_LOW   = 2'd0;
    localparam logic [1:0] QUAL_LIN   = 2'd1;
    localparam logic [1:0] QUAL_CUBIC = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // one read's gathered words plus what the interpolator needs
    typedef struct packed {
        logic [SLOT_N-1:0][WORD_W-1:0] words;
        logic [FRAC_W-1:0]             t;
        logic [BLEND_W-1:0]            u;
        logic                          cubic;
        logic [MIPO_W-1:0]             mip;
    } job_t;

endpackage

`default_nettype wire

[design/mwr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[design/mwr_fetch.sv]
`timescale 1ns / 1ps
`default_nettype none

module mwr_fetch
    import mwr_pkg::*;
#(
    parameter int TABLE_LEN   = 2048,
    parameter int FRAME_COUNT = 64,
    parameter int MIP_COUNT   = 10,
    parameter int BANK_COUNT  = 2,
    parameter int AW          = 23
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          req_type,
    input  wire logic          bank_sel,
    input  wire logic [5:0]    wr_frame,
    input  wire logic [3:0]    wr_mip,
    input  wire logic [10:0]   wr_sample,
    input  wire logic [15:0]   wr_value,
    input  wire logic [16:0]   frame_pos,
    input  wire logic [23:0]   read_phase,
    input  wire logic [23:0]   phase_step,
    input  wire logic [1:0]    quality,
    output logic               ram_we,
    output logic [AW-1:0]      ram_addr,
    output logic [WORD_W-1:0]  ram_wdata,
    input  wire logic [WORD_W-1:0] ram_rdata,
    output job_t               job,
    output logic               job_valid,
    input  wire logic          job_take
);

    localparam int SW = $clog2(TABLE_LEN);
    localparam int FW = $clog2(FRAME_COUNT);
    localparam int MW = (MIP_COUNT > 1) ? $clog2(MIP_COUNT) : 1;
    localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;

    logic            busy_reg, busy_next;
    logic            rd_pend_reg;
    logic            job_valid_reg, job_valid_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [2:0]      slot_d_reg;
    logic            last_d_reg;
    logic [BW-1:0]   bank_reg;
    logic [FW-1:0]   f0_reg;
    logic [MW-1:0]   mip_reg;
    logic [SW-1:0]   s0_reg;
    job_t            job_reg;

    logic            accept;
    logic            wr_ok;
    logic [24+SW:0]  s_pos;
    logic [24:0]     f_idx;
    logic [16:0]     fsat;
    logic [8:0]      f0_full;
    logic [8:0]      f0_c;
    logic [19:0]     ptop;
    logic [36:0]     p_step;
    logic [4:0]      mip_sel;
    logic [4:0]      mip_q;
    logic [BW-1:0]   bank_rd;
    logic [2:0]      slot;
    logic [2:0]      last_cnt;
    logic [SW+1:0]   sx;
    logic [SW-1:0]   s_rd;
    logic [FW-1:0]   f_rd;

    assign in_ready = !busy_reg && !rd_pend_reg && (!job_valid_reg || job_take);
    assign accept   = in_valid && in_ready;
    assign wr_ok    = (32'(bank_sel) < BANK_COUNT) && (32'(wr_frame) < FRAME_COUNT)
                   && (32'(wr_mip) < MIP_COUNT) && (32'(wr_sample) < TABLE_LEN);

    // index math for a read beat
    always_comb
    begin
        p_step = 37'(phase_step) * 37'(TABLE_LEN);
        ptop   = 20'(p_step >> 24);
        mip_sel = 5'(MIP_COUNT - 1);
        for (int m = MIP_COUNT - 2; m >= 0; m--)
        begin
            if (ptop < (20'd32 << m))
            begin
                mip_sel = 5'(m);
            end
        end
        mip_q = mip_sel;
        if (quality == QUAL_LOW)
        begin
            mip_q = (mip_sel + 5'd2 > 5'(MIP_COUNT - 1)) ? 5'(MIP_COUNT - 1)
                                                         : mip_sel + 5'd2;
        end
        bank_rd = (32'(bank_sel) >= BANK_COUNT) ? BW'(BANK_COUNT - 1) : BW'(bank_sel);
        fsat    = (frame_pos > 17'd65536) ? 17'd65536 : frame_pos;
        f_idx   = 25'(fsat) * 25'(FRAME_COUNT - 1);
        f0_full = f_idx[24:16];
        f0_c    = (32'(f0_full) >= FRAME_COUNT - 1) ? 9'(FRAME_COUNT - 2) : f0_full;
        s_pos   = (25 + SW)'(read_phase) * (25 + SW)'(TABLE_LEN);
    end

    // slot order: cubic walks all eight, linear only the two center taps per frame
    always_comb
    begin
        slot     = job_reg.cubic ? cnt_reg : {cnt_reg[1], cnt_reg[0], ~cnt_reg[0]};
        last_cnt = job_reg.cubic ? 3'd7 : 3'd3;
        sx = (SW + 2)'(s0_reg) + (SW + 2)'(slot[1:0]) + (SW + 2)'(TABLE_LEN - 1);
        if (32'(sx) >= 2 * TABLE_LEN)
        begin
            s_rd = SW'(32'(sx) - 2 * TABLE_LEN);
        end
        else if (32'(sx) >= TABLE_LEN)
        begin
            s_rd = SW'(32'(sx) - TABLE_LEN);
        end
        else
        begin
            s_rd = SW'(sx);
        end
        f_rd = f0_reg + FW'(slot[2]);
    end

    always_comb
    begin
        ram_we    = accept && (req_type == REQ_WRITE) && wr_ok;
        ram_wdata = wr_value;
        if (busy_reg)
        begin
            ram_addr = {bank_reg, f_rd, mip_reg, s_rd};
        end
        else
        begin
            ram_addr = {BW'(bank_sel), FW'(wr_frame), MW'(wr_mip), SW'(wr_sample)};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (accept && (req_type == REQ_READ))
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == last_cnt)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 3'd1;
            end
        end
        job_valid_next = (job_valid_reg && !job_take) || (rd_pend_reg && last_d_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rd_pend_reg   <= 1'b0;
            job_valid_reg <= 1'b0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            rd_pend_reg   <= busy_reg;
            job_valid_reg <= job_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_d_reg <= slot;
        last_d_reg <= (cnt_reg == last_cnt);
        if (accept && (req_type == REQ_READ))
        begin
            bank_reg      <= bank_rd;
            f0_reg        <= FW'(f0_c);
            mip_reg       <= MW'(mip_q);
            s0_reg        <= SW'(s_pos[24+SW:24]);
            job_reg.t     <= s_pos[23:8];
            job_reg.u     <= 17'(f_idx - {f0_c, 16'b0});
            job_reg.cubic <= (quality == QUAL_CUBIC);
            job_reg.mip   <= 4'(mip_q);
        end
        if (rd_pend_reg)
        begin
            job_reg.words[slot_d_reg] <= ram_rdata;
        end
    end

    assign job       = job_reg;
    assign job_valid = job_valid_reg;

    a_no_fill_over_job: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !job_valid_reg)
        else $error("read data lands on a pending job");
    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !busy_reg && !rd_pend_reg)
        else $error("table write collides with a read sweep");
    a_job_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(job_valid_reg) |-> $past(rd_pend_reg) && !busy_reg)
        else $error("job raised without a finished sweep");

endmodule

`default_nettype wire

[design/mwr_interp.sv]
`timescale 1ns / 1ps
`default_nettype none

module mwr_interp
    import mwr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire job_t         job,
    input  wire logic         job_valid,
    output logic              job_take,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [OUT_W-1:0]  sample_out,
    output logic [MIPO_W-1:0] mip_used
);

    logic en;
    logic [5:1] v_reg;

    logic                      s1_cubic_reg, s2_cubic_reg, s3_cubic_reg;
    logic [FRAC_W-1:0]         s1_t_reg, s2_t_reg, s3_t_reg;
    logic [BLEND_W-1:0]        s1_u_reg, s2_u_reg, s3_u_reg, s4_u_reg;
    logic [MIPO_W-1:0]         s1_mip_reg, s2_mip_reg, s3_mip_reg, s4_mip_reg, s5_mip_reg;
    logic signed [19:0]        s1_coef_reg [2];
    logic signed [VAL_W-1:0]   s1_base_reg [2];
    logic signed [16:0]        s1_c1_reg [2], s2_c1_reg [2];
    logic signed [15:0]        s1_y1_reg [2], s2_y1_reg [2], s3_y1_reg [2];
    logic signed [VAL_W-1:0]   s2_a_reg [2], s3_a_reg [2], s4_v_reg [2];
    logic signed [VAL_W:0]     s5_r_reg;
    logic signed [OUT_W-1:0]   out_reg;
    logic [MIPO_W-1:0]         mip_out_reg;

    logic signed [19:0]        c2 [2], c3 [2], coef [2];
    logic signed [16:0]        c1 [2], dl [2];
    logic signed [15:0]        y [2][4];
    logic signed [VAL_W+16:0]  p1 [2], p2 [2], p3 [2];
    logic signed [VAL_W-1:0]   a1 [2], a2 [2], vx [2];
    logic signed [VAL_W:0]     d;
    logic signed [VAL_W+18:0]  pd;
    logic signed [VAL_W:0]     r;
    logic signed [VAL_W:0]     rr;
    logic signed [FRAC_W:0]    ts1, ts2, ts3;

    // stall everything while the output beat waits
    assign en       = !out_valid || out_ready;
    assign job_take = en && job_valid;

    always_comb
    begin
        ts1 = $signed({1'b0, s1_t_reg});
        ts2 = $signed({1'b0, s2_t_reg});
        ts3 = $signed({1'b0, s3_t_reg});
        for (int l = 0; l < 2; l++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                y[l][k] = $signed(job.words[4 * l + k]);
            end
            c1[l] = 17'(y[l][2]) - 17'(y[l][0]);
            c2[l] = 20'(y[l][0]) * 20'sd2 - 20'(y[l][1]) * 20'sd5
                  + 20'(y[l][2]) * 20'sd4 - 20'(y[l][3]);
            c3[l] = 20'(y[l][3]) - 20'(y[l][0]) + (20'(y[l][1]) - 20'(y[l][2])) * 20'sd3;
            dl[l] = 17'(y[l][2]) - 17'(y[l][1]);
            coef[l] = job.cubic ? c3[l] : 20'(dl[l]);
            p1[l] = s1_coef_reg[l] * ts1;
            a1[l] = s1_base_reg[l] + VAL_W'(p1[l]);
            p2[l] = s2_a_reg[l] * ts2;
            a2[l] = s2_cubic_reg ? ((VAL_W'(s2_c1_reg[l]) <<< 16) + VAL_W'(p2[l] >>> 16))
                                 : s2_a_reg[l];
            p3[l] = s3_a_reg[l] * ts3;
            vx[l] = s3_cubic_reg
                  ? ((VAL_W'(s3_y1_reg[l]) <<< 17) + VAL_W'(p3[l] >>> 16)) >>> 1
                  : s3_a_reg[l];
        end
        d  = (VAL_W + 1)'(s4_v_reg[1]) - (VAL_W + 1)'(s4_v_reg[0]);
        pd = d * $signed({1'b0, s4_u_reg});
        r  = (VAL_W + 1)'(s4_v_reg[0]) + (VAL_W + 1)'(pd >>> 16);
        rr = (s5_r_reg + (VAL_W + 1)'(32768)) >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[4:1], job_valid};
            out_valid <= v_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cubic_reg <= job.cubic;
            s1_t_reg     <= job.t;
            s1_u_reg     <= job.u;
            s1_mip_reg   <= job.mip;
            s2_cubic_reg <= s1_cubic_reg;
            s2_t_reg     <= s1_t_reg;
            s2_u_reg     <= s1_u_reg;
            s2_mip_reg   <= s1_mip_reg;
            s3_cubic_reg <= s2_cubic_reg;
            s3_t_reg     <= s2_t_reg;
            s3_u_reg     <= s2_u_reg;
            s3_mip_reg   <= s2_mip_reg;
            s4_u_reg     <= s3_u_reg;
            s4_mip_reg   <= s3_mip_reg;
            s5_mip_reg   <= s4_mip_reg;
            for (int l = 0; l < 2; l++)
            begin
                s1_coef_reg[l] <= coef[l];
                s1_base_reg[l] <= job.cubic ? (VAL_W'(c2[l]) <<< 16)
                                            : (VAL_W'(y[l][1]) <<< 16);
                s1_c1_reg[l]   <= c1[l];
                s1_y1_reg[l]   <= y[l][1];
                s2_a_reg[l]    <= a1[l];
                s2_c1_reg[l]   <= s1_c1_reg[l];
                s2_y1_reg[l]   <= s1_y1_reg[l];
                s3_a_reg[l]    <= a2[l];
                s3_y1_reg[l]   <= s2_y1_reg[l];
                s4_v_reg[l]    <= vx[l];
            end
            s5_r_reg <= r;
            if (rr > (VAL_W + 1)'(131071))
            begin
                out_reg <= 18'sd131071;
            end
            else if (rr < -(VAL_W + 1)'(131072))
            begin
                out_reg <= -18'sd131072;
            end
            else
            begin
                out_reg <= OUT_W'(rr);
            end
            mip_out_reg <= s5_mip_reg;
        end
    end

    assign sample_out = out_reg;
    assign mip_used   = mip_out_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(v_reg))
        else $error("pipeline moved under a stalled output");
    a_take_only_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> en)
        else $error("job taken while pipeline stalled");
    a_fill_tracks_take: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> v_reg[1])
        else $error("taken job did not enter the pipeline");

endmodule

`default_nettype wire

[design/mipmapped_wavetable_read.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake            | Beat contents
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | req_type, bank_sel, wr_*, frame_pos, phases
// out      | out_valid / out_ready| sample_out, mip_used (one beat per read)
// cfg      | cfg_we               | cfg_wdata -> quality_reg
//
// Reads: a read beat holds the input while the sweep reads its table words
// (linear: 4 table words, cubic: 8 table words); the single port of the sample
// memory, one word per cycle, sets this. Results then pass through a 6-stage
// interpolation pipeline.
// Reset: control state clears at once; the sample memory is not cleared and a
// word must be written before it is read.
// Stalls: a held output freezes the interpolation pipeline; the next read's
// word sweep still runs and parks its words until the pipeline moves again.

module mipmapped_wavetable_read
    import mwr_pkg::*;
#(
    parameter int TABLE_LEN   = 2048,
    parameter int FRAME_COUNT = 64,
    parameter int MIP_COUNT   = 10,
    parameter int BANK_COUNT  = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic        bank_sel,
    input  wire logic [5:0]  wr_frame,
    input  wire logic [3:0]  wr_mip,
    input  wire logic [10:0] wr_sample,
    input  wire logic [15:0] wr_value,
    input  wire logic [16:0] frame_pos,
    input  wire logic [23:0] read_phase,
    input  wire logic [23:0] phase_step,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [17:0]      sample_out,
    output logic [3:0]       mip_used,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata
);

    localparam int SW = $clog2(TABLE_LEN);
    localparam int FW = $clog2(FRAME_COUNT);
    localparam int MW = (MIP_COUNT > 1) ? $clog2(MIP_COUNT) : 1;
    localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int AW = BW + FW + MW + SW;

    logic [1:0]        quality_reg;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    job_t              job;
    logic              job_valid;
    logic              job_take;

    // quality register; user writes it only while the block is idle, unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quality_reg <= QUAL_LIN;
        end
        else if (cfg_we)
        begin
            quality_reg <= cfg_wdata;
        end
    end

    // address = {bank, frame, mip, sample}, each field padded to a power of two
    mwr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (2 ** AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // decode the beat, drive table writes, sweep the taps, gather words
    mwr_fetch #(
        .TABLE_LEN   (TABLE_LEN),
        .FRAME_COUNT (FRAME_COUNT),
        .MIP_COUNT   (MIP_COUNT),
        .BANK_COUNT  (BANK_COUNT),
        .AW          (AW)
    ) u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .bank_sel   (bank_sel),
        .wr_frame   (wr_frame),
        .wr_mip     (wr_mip),
        .wr_sample  (wr_sample),
        .wr_value   (wr_value),
        .frame_pos  (frame_pos),
        .read_phase (read_phase),
        .phase_step (phase_step),
        .quality    (quality_reg),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .job        (job),
        .job_valid  (job_valid),
        .job_take   (job_take)
    );

    // Horner (cubic) or linear step per frame, frame blend, round and saturate
    mwr_interp u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job),
        .job_valid  (job_valid),
        .job_take   (job_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .mip_used   (mip_used)
    );

endmodule

`default_nettype wire

[tb/sv/mipmapped_wavetable_read_tb.sv]
`timescale 1ns / 1ps

// Beat sent on the request channel, one field per port.
typedef struct {
    logic        req;
    logic        bank;
    logic [5:0]  frame;
    logic [3:0]  mip;
    logic [10:0] sample;
    logic [15:0] value;
    logic [16:0] fpos;
    logic [23:0] phase;
    logic [23:0] step;
} wt_req_t;

typedef struct {
    logic [17:0] sample;
    logic [3:0]  mip;
} wt_sample_t;

// Shadow wavetable plus quality setting; predicts each read's sample.
class wavetable_scoreboard;
    logic signed [15:0] table_words[int];
    logic [1:0]         quality;
    wt_sample_t         pending_samples[$];
    int                 mismatches;
    int                 orphans;
    int                 reads_checked;

    function new();
        quality = mwr_pkg::QUAL_LIN;
        mismatches = 0;
        orphans = 0;
        reads_checked = 0;
    endfunction

    function int word_addr(int bank, int frame, int mip, int s);
        return ((bank * 64 + frame) * 10 + mip) * 2048 + s;
    endfunction

    function int level_for(logic [23:0] step);
        longint p;
        int lvl;
        p = longint'(step) * 2048;
        lvl = 9;
        for (int m = 8; m >= 0; m--)
            if (p < ((longint'(32) << m) << 24))
                lvl = m;
        if (quality == mwr_pkg::QUAL_LOW)
            lvl = (lvl + 2 > 9) ? 9 : lvl + 2;
        return lvl;
    endfunction

    function int first_frame(logic [16:0] fpos);
        longint fp;
        int f0;
        fp = (fpos > 65536) ? 65536 : fpos;
        f0 = int'((fp * 63) >> 16);
        return (f0 >= 63) ? 62 : f0;
    endfunction

    function longint word_at(int bank, int frame, int mip, int s);
        int a;
        a = word_addr(bank, frame, mip, s);
        return table_words.exists(a) ? longint'(table_words[a]) : 0;
    endfunction

    // Interpolated value inside one frame, Q.16 (16 fraction bits)
    function longint frame_interp(int bank, int frame, int mip, int s0, longint t);
        longint y0, y1, y2, y3, c1, c2, c3, acc;
        y1 = word_at(bank, frame, mip, s0);
        y2 = word_at(bank, frame, mip, (s0 + 1) % 2048);
        if (quality != mwr_pkg::QUAL_CUBIC)
            return y1 * 65536 + (y2 - y1) * t;
        y0 = word_at(bank, frame, mip, (s0 + 2047) % 2048);
        y3 = word_at(bank, frame, mip, (s0 + 2) % 2048);
        c1 = y2 - y0;
        c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        c3 = y3 - y0 + 3 * (y1 - y2);
        acc = c2 * 65536 + c3 * t;
        acc = c1 * 65536 + ((acc * t) >>> 16);
        acc = 2 * y1 * 65536 + ((acc * t) >>> 16);
        return acc >>> 1;
    endfunction

    function void note_request(wt_req_t r);
        longint fp, fi, u, sp, t, v0, v1, acc;
        int f0, s0, lvl;
        wt_sample_t exp_s;
        if (r.req == mwr_pkg::REQ_WRITE) begin
            if (r.mip < 10)
                table_words[word_addr(r.bank, r.frame, r.mip, r.sample)] = r.value;
            return;
        end
        lvl = level_for(r.step);
        fp = (r.fpos > 65536) ? 65536 : r.fpos;
        fi = fp * 63;
        f0 = first_frame(r.fpos);
        u = fi - (longint'(f0) << 16);
        sp = longint'(r.phase) * 2048;
        s0 = int'((sp >> 24) % 2048);
        t = (sp & 64'hFFFFFF) >> 8;
        v0 = frame_interp(r.bank, f0, lvl, s0, t);
        v1 = frame_interp(r.bank, f0 + 1, lvl, s0, t);
        acc = v0 + (((v1 - v0) * u) >>> 16);
        acc = (acc + 32768) >>> 16;
        if (acc > 131071)
            acc = 131071;
        if (acc < -131072)
            acc = -131072;
        exp_s.sample = acc[17:0];
        exp_s.mip = lvl[3:0];
        pending_samples.push_back(exp_s);
    endfunction

    function void check_sample(logic [17:0] sample, logic [3:0] mip);
        wt_sample_t e;
        if (pending_samples.size() == 0) begin
            orphans++;
            $display("unexpected output beat: sample_out=%0h mip_used=%0d", sample, mip);
            return;
        end
        e = pending_samples.pop_front();
        reads_checked++;
        if (sample !== e.sample || mip !== e.mip) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: sample_out exp %0h got %0h, mip_used exp %0d got %0d",
                         e.sample, sample, e.mip, mip);
        end
    endfunction
endclass

module mipmapped_wavetable_read_tb;
    import mwr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic        bank_sel;
    logic [5:0]  wr_frame;
    logic [3:0]  wr_mip;
    logic [10:0] wr_sample;
    logic [15:0] wr_value;
    logic [16:0] frame_pos;
    logic [23:0] read_phase;
    logic [23:0] phase_step;
    logic        out_valid;
    logic        out_ready;
    logic [17:0] sample_out;
    logic [3:0]  mip_used;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;

    wavetable_scoreboard wt_sb;
    bit  steady_stretch;   // set while neither side may idle
    int  beats_sent;
    int  reads_sent;

    mipmapped_wavetable_read DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .bank_sel   (bank_sel),
        .wr_frame   (wr_frame),
        .wr_mip     (wr_mip),
        .wr_sample  (wr_sample),
        .wr_value   (wr_value),
        .frame_pos  (frame_pos),
        .read_phase (read_phase),
        .phase_step (phase_step),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .mip_used   (mip_used),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Output side: stall at random about 35 percent of the time, except in the steady stretch.
    always @(negedge clk)
    begin
        out_ready <= steady_stretch || ($urandom_range(0, 99) >= 35);
    end

    // Check every accepted result beat at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            wt_sb.check_sample(sample_out, mip_used);
    end

    // Send one beat; idle first at random, hold valid and payload until accepted.
    task automatic send_beat(wt_req_t r);
        @(negedge clk);
        while (!steady_stretch && $urandom_range(0, 99) < 35) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= r.req;
        bank_sel   <= r.bank;
        wr_frame   <= r.frame;
        wr_mip     <= r.mip;
        wr_sample  <= r.sample;
        wr_value   <= r.value;
        frame_pos  <= r.fpos;
        read_phase <= r.phase;
        phase_step <= r.step;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        wt_sb.note_request(r);
        beats_sent++;
    endtask

    function automatic wt_req_t noise_fields();
        wt_req_t r;
        r.req    = REQ_WRITE;
        r.bank   = 1'($urandom);
        r.frame  = 6'($urandom);
        r.mip    = 4'($urandom_range(0, 9));
        r.sample = 11'($urandom);
        r.value  = 16'($urandom);
        r.fpos   = 17'($urandom);
        r.phase  = 24'($urandom);
        r.step   = 24'($urandom);
        return r;
    endfunction

    function automatic logic [15:0] table_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_word(logic bank, int frame, int mip, int s, logic [15:0] v);
        wt_req_t r;
        r = noise_fields();
        r.bank = bank;
        r.frame = 6'(frame);
        r.mip = 4'(mip);
        r.sample = 11'(s);
        r.value = v;
        send_beat(r);
    endtask

    // Fill any of the eight words around this read (two frames, four taps) that were never written, then read.
    task automatic read_sample(logic bank, logic [16:0] fpos, logic [23:0] phase,
                               logic [23:0] step);
        wt_req_t r;
        int lvl, f0, s0, s;
        lvl = wt_sb.level_for(step);
        f0 = wt_sb.first_frame(fpos);
        s0 = int'(((longint'(phase) * 2048) >> 24) % 2048);
        for (int f = f0; f <= f0 + 1; f++)
            for (int k = -1; k <= 2; k++) begin
                s = (s0 + k + 2048) % 2048;
                if (!wt_sb.table_words.exists(wt_sb.word_addr(bank, f, lvl, s)))
                    write_word(bank, f, lvl, s, table_value());
            end
        r = noise_fields();
        r.req = REQ_READ;
        r.bank = bank;
        r.fpos = fpos;
        r.phase = phase;
        r.step = step;
        send_beat(r);
        reads_sent++;
    endtask

    // Drain outstanding reads, let the pipeline settle, then change quality.
    task automatic set_quality(logic [1:0] q);
        @(negedge clk);
        in_valid <= 1'b0;
        while (wt_sb.pending_samples.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= q;
        @(negedge clk);
        cfg_we <= 1'b0;
        wt_sb.quality = q;
    endtask

    // Oscillator-like read: mostly continue the last phase, sometimes jump.
    task automatic random_read(ref logic [23:0] phase, ref logic [23:0] step,
                               ref logic [16:0] fpos, ref logic bank);
        if ($urandom_range(0, 3) == 0) begin
            bank = 1'($urandom);
            step = 24'($urandom) >> $urandom_range(0, 23);
            fpos = ($urandom_range(0, 9) == 0) ? 17'($urandom)
                                               : 17'($urandom_range(0, 65536));
            phase = 24'($urandom);
        end else begin
            phase = phase + step;
            if ($urandom_range(0, 3) == 0)
                fpos = 17'($urandom_range(0, 65536));
        end
        read_sample(bank, fpos, phase, step);
    endtask

    initial
    begin
        logic [23:0] ph, st;
        logic [16:0] fp;
        logic        bk;
        logic [1:0]  qual_seq[6];
        wt_req_t     r;
        int          fails;

        wt_sb = new();
        steady_stretch = 1'b0;
        beats_sent = 0;
        reads_sent = 0;
        in_valid = 1'b0;
        req_type = REQ_WRITE;
        bank_sel = 1'b0;
        wr_frame = '0;
        wr_mip = '0;
        wr_sample = '0;
        wr_value = '0;
        frame_pos = '0;
        read_phase = '0;
        phase_step = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = QUAL_LIN;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes at reset quality (linear).
        write_word(1'b0, 0, 0, 0, 16'h8000);
        write_word(1'b1, 63, 9, 2047, 16'h7FFF);
        // mip beyond the table count must be ignored
        r = noise_fields();
        r.mip = 4'd15;
        send_beat(r);
        r.mip = 4'd10;
        send_beat(r);
        read_sample(1'b0, 17'd0, 24'd0, 24'd0);
        read_sample(1'b1, 17'd65536, 24'hFFFFFF, 24'hFFFFFF);
        read_sample(1'b1, 17'h1FFFF, 24'h800000, 24'h000400);
        read_sample(1'b0, 17'd32768, 24'h7FF00, 24'h1FFFF);

        // Directed: every quality, including the unused code, with extreme words.
        qual_seq = '{QUAL_CUBIC, QUAL_LOW, 2'd3, QUAL_CUBIC, QUAL_LOW, QUAL_LIN};
        foreach (qual_seq[i]) begin
            set_quality(qual_seq[i]);
            read_sample(1'b0, 17'd0, 24'd0, 24'd0);
            read_sample(1'b1, 17'd65536, 24'hFFFFFF, 24'hFFFFFF);
            read_sample(1'b0, 17'd40000, 24'd8191, 24'h00003F);
        end

        // Random phases; steady stretch in the middle of the third one.
        ph = '0;
        st = 24'h1000;
        fp = '0;
        bk = 1'b0;
        for (int phase_no = 0; phase_no < 6; phase_no++) begin
            set_quality(qual_seq[phase_no]);
            for (int n = 0; n < 35; n++) begin
                if (phase_no == 2)
                    steady_stretch = (n >= 5 && n < 30);
                if ($urandom_range(0, 4) == 0)
                    send_beat(noise_fields());
                else
                    random_read(ph, st, fp, bk);
            end
            steady_stretch = 1'b0;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (wt_sb.pending_samples.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        fails = wt_sb.mismatches + wt_sb.orphans + wt_sb.pending_samples.size();
        $display("Sent %0d beats (%0d reads), checked %0d samples over all quality settings.",
                 beats_sent, reads_sent, wt_sb.reads_checked);
        $display("Mismatches %0d, unexpected beats %0d.", wt_sb.mismatches, wt_sb.orphans);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
